/* hdl/sparse_matrix_accumulate_defines.svh */
// Assertion macros used by the sparse matrix accumulate RTL.
// Depends on nothing; included by sparse_matrix_accumulate, which carries the assertions.
`ifndef SPARSE_MATRIX_ACCUMULATE_DEFINES_SVH
`define SPARSE_MATRIX_ACCUMULATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SMACC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smacc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SMACC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smacc assertion failed");

`endif

/* hdl/smacc_pkg.sv */
// Package for the sparse matrix accumulate block: sizes, request codes,
// sequencer states and the flag struct of the scan unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smacc_pkg;

   // Matrix sizes.
   localparam int NUM_DOF     = 256;
   localparam int NUM_NONZERO = 4096;

   // Field widths of the item and the result.
   localparam int REQ_W   = 3;
   localparam int ROW_W   = 8;
   localparam int COL_W   = 8;
   localparam int ADDR_W  = 12;
   localparam int PTR_W   = 13;
   localparam int VALUE_W = 48;
   localparam int POS_W   = 12;

   // Storage geometry.
   localparam int CS_DEPTH = NUM_DOF + 1;
   localparam int CS_AW    = $clog2(CS_DEPTH);
   localparam int ENTRY_AW = $clog2(NUM_NONZERO);

   // Packed port widths.
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 64;

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD_PTR = 3'd0,
      REQ_LOAD_ROW = 3'd1,
      REQ_ACCUM    = 3'd2,
      REQ_READ     = 3'd3,
      REQ_CLEAR    = 3'd4
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_PTR_LO,
      ST_PTR_HI,
      ST_SCAN,
      ST_CHECK,
      ST_READ_WAIT,
      ST_RESULT
   } state_type;

   // Flags from the scan unit to the sequencer.
   typedef struct packed {
      logic more;
      logic hit;
   } alu_flags_type;

endpackage

`default_nettype wire

/* hdl/smacc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/smacc_alu.sv */
// Shared scan unit: bound compare, row match, index increment and
// saturating 48-bit add. Depends on smacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smacc_alu
   import smacc_pkg::*;
(
   input  wire logic        [PTR_W-1:0]   scan_index,
   input  wire logic        [PTR_W-1:0]   scan_end,
   input  wire logic        [ROW_W-1:0]   key_row,
   input  wire logic        [ROW_W-1:0]   entry_row,
   input  wire logic signed [VALUE_W-1:0] acc_value,
   input  wire logic signed [VALUE_W-1:0] contribution,
   output alu_flags_type                  flags,
   output logic             [PTR_W-1:0]   next_index,
   output logic signed      [VALUE_W-1:0] sum
);

   localparam logic [VALUE_W-1:0] MAX_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

   logic [VALUE_W:0] wide_sum;

   // The scan continues while the index is below the column end and the store size.
   assign flags.more = (scan_index < scan_end) && (32'(scan_index) < NUM_NONZERO);
   assign flags.hit  = (entry_row == key_row);
   assign next_index = scan_index + PTR_W'(1);

   // Add with one guard bit; clamp when the guard and sign bits differ.
   assign wide_sum = {acc_value[VALUE_W-1], acc_value}
                   + {contribution[VALUE_W-1], contribution};

   always_comb begin
      if (wide_sum[VALUE_W] != wide_sum[VALUE_W-1]) begin
         sum = wide_sum[VALUE_W] ? MIN_VALUE : MAX_VALUE;
      end else begin
         sum = wide_sum[VALUE_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* hdl/sparse_matrix_accumulate.sv */
// Sparse matrix accumulate block in compressed-column form. After reset the
// block zeroes all NUM_NONZERO (4096) value entries and holds req_tready
// low meanwhile. It then works on one item at a time: every item passes
// ST_EXEC and then ST_RESULT; an in-range read adds ST_READ_WAIT, and an
// accumulate with a valid column reads the column start and end in ST_PTR_LO
// and ST_PTR_HI, then alternates ST_SCAN and ST_CHECK for each column entry
// examined, up to and including the match, or until the column ends with no
// match. The scan is paced by the entry-row RAM: an address is read in ST_SCAN
// and its registered data compared in ST_CHECK. A new item is accepted once
// the previous result sits in the output register, even if it is not yet taken.
// Depends on smacc_pkg, smacc_ram, smacc_alu and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_matrix_accumulate_defines.svh"

module sparse_matrix_accumulate
   import smacc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: row[7:0], col[15:8], addr[27:16], load_data[40:28],
   //        contribution[88:41], zero fill above.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: req_type[2:0].
   input  wire logic [REQ_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: status[0], position[12:1], read_value[60:13], zero fill above.
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   // Sequencer and result state.
   state_type                 state_ff, state_in;
   logic [ENTRY_AW-1:0]       clr_ff, clr_in;
   logic [PTR_W-1:0]          k_ff, k_in;
   logic [PTR_W-1:0]          end_ff, end_in;
   logic                      res_status_ff, res_status_in;
   logic [POS_W-1:0]          res_pos_ff, res_pos_in;
   logic [VALUE_W-1:0]        res_value_ff, res_value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // Captured item.
   req_kind_type              kind_ff;
   logic [ROW_W-1:0]          row_ff;
   logic [COL_W-1:0]          col_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [PTR_W-1:0]          load_ff;
   logic [VALUE_W-1:0]        contrib_ff;

   // Memory ports.
   logic                      cs_we;
   logic [CS_AW-1:0]          cs_waddr, cs_raddr;
   logic [PTR_W-1:0]          cs_rdata;
   logic                      row_we;
   logic [ENTRY_AW-1:0]       row_waddr, row_raddr;
   logic [ROW_W-1:0]          row_wdata, row_rdata;
   logic                      val_we;
   logic [ENTRY_AW-1:0]       val_waddr, val_raddr;
   logic [VALUE_W-1:0]        val_wdata, val_rdata;

   // Scan unit results.
   alu_flags_type             flags;
   logic [PTR_W-1:0]          next_index;
   logic [VALUE_W-1:0]        sum;

   logic                      req_accept;
   logic                      ptr_ok;
   logic                      entry_ok;
   logic                      col_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Range checks on the captured item.
   assign ptr_ok   = (32'(addr_ff) <= NUM_DOF);
   assign entry_ok = (32'(addr_ff) < NUM_NONZERO);
   assign col_ok   = (32'(col_ff) < NUM_DOF);

   // Column start pointers.
   smacc_ram #(.WIDTH(PTR_W), .DEPTH(CS_DEPTH)) u_col_start (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (cs_waddr),
      .wr_data (load_ff),
      .rd_addr (cs_raddr),
      .rd_data (cs_rdata)
   );

   // Row index of each stored entry.
   smacc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_NONZERO)) u_entry_row (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   // Value of each stored entry.
   smacc_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_NONZERO)) u_entry_value (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   // Shared compare and add unit.
   smacc_alu u_alu (
      .scan_index   (k_ff),
      .scan_end     (end_ff),
      .key_row      (row_ff),
      .entry_row    (row_rdata),
      .acc_value    (val_rdata),
      .contribution (contrib_ff),
      .flags        (flags),
      .next_index   (next_index),
      .sum          (sum)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      end_ff        <= end_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_value_ff  <= res_value_in;
      rsp_data_ff   <= rsp_data_in;
      if (req_accept) begin
         kind_ff    <= req_kind_type'(req_tuser);
         row_ff     <= req_tdata[7:0];
         col_ff     <= req_tdata[15:8];
         addr_ff    <= req_tdata[27:16];
         load_ff    <= req_tdata[40:28];
         contrib_ff <= req_tdata[88:41];
      end
   end

   // Next state, memory controls and result staging.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      k_in          = k_ff;
      end_in        = end_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      cs_we     = 1'b0;
      cs_waddr  = CS_AW'(addr_ff);
      cs_raddr  = CS_AW'(col_ff);
      row_we    = 1'b0;
      row_waddr = ENTRY_AW'(addr_ff);
      row_wdata = load_ff[ROW_W-1:0];
      row_raddr = ENTRY_AW'(k_ff);
      val_we    = 1'b0;
      val_waddr = ENTRY_AW'(addr_ff);
      val_wdata = '0;
      val_raddr = ENTRY_AW'(k_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one value entry per cycle after reset.
            val_we    = 1'b1;
            val_waddr = clr_ff;
            clr_in    = clr_ff + ENTRY_AW'(1);
            if (clr_ff == ENTRY_AW'(NUM_NONZERO - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Default result for loads, clears and rejected items.
            res_status_in = 1'b0;
            res_pos_in    = POS_W'(addr_ff);
            res_value_in  = '0;
            state_in      = ST_RESULT;
            unique case (kind_ff)
               REQ_LOAD_PTR: begin
                  cs_we         = ptr_ok;
                  res_status_in = !ptr_ok;
               end
               REQ_LOAD_ROW: begin
                  row_we        = entry_ok;
                  res_status_in = !entry_ok;
               end
               REQ_ACCUM: begin
                  // Read the column start; the end follows next cycle.
                  if (col_ok) begin
                     state_in = ST_PTR_LO;
                  end else begin
                     res_status_in = 1'b1;
                     res_pos_in    = '0;
                  end
               end
               REQ_READ: begin
                  val_raddr     = ENTRY_AW'(addr_ff);
                  res_status_in = !entry_ok;
                  if (entry_ok) begin
                     state_in = ST_READ_WAIT;
                  end
               end
               REQ_CLEAR: begin
                  val_we        = entry_ok;
                  res_status_in = !entry_ok;
               end
               default: begin
                  res_status_in = 1'b1;
                  res_pos_in    = '0;
               end
            endcase
         end
         ST_PTR_LO: begin
            cs_raddr = CS_AW'(col_ff) + CS_AW'(1);
            k_in     = cs_rdata;
            state_in = ST_PTR_HI;
         end
         ST_PTR_HI: begin
            end_in   = cs_rdata;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Entry reads at the scan index are issued here.
            if (flags.more) begin
               state_in = ST_CHECK;
            end else begin
               res_status_in = 1'b1;
               res_pos_in    = '0;
               res_value_in  = '0;
               state_in      = ST_RESULT;
            end
         end
         ST_CHECK: begin
            // On a match, write back the saturated sum; otherwise step on.
            if (flags.hit) begin
               val_we        = 1'b1;
               val_waddr     = ENTRY_AW'(k_ff);
               val_wdata     = sum;
               res_status_in = 1'b0;
               res_pos_in    = POS_W'(k_ff);
               res_value_in  = sum;
               state_in      = ST_RESULT;
            end else begin
               k_in     = next_index;
               state_in = ST_SCAN;
            end
         end
         ST_READ_WAIT: begin
            res_value_in = val_rdata;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_value_ff, res_pos_ff, res_status_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A match always yields an ok result.
   `SMACC_ASSERT_NEXT(a_hit_ok, clock, reset, (state_ff == ST_CHECK) && flags.hit,
                      (state_ff == ST_RESULT) && !res_status_ff)
   // An entry is only examined inside its column range.
   `SMACC_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == ST_CHECK,
                      (k_ff < end_ff) && (32'(k_ff) < NUM_NONZERO))
   // The value sweep starts from entry zero when reset drops.
   `SMACC_ASSERT_IMPL(a_sweep_start, clock, reset, $fell(reset),
                      (state_ff == ST_CLEAR) && (clr_ff == '0))
   // A new result appears only from the result stage.
   `SMACC_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
                      $past(state_ff) == ST_RESULT)

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the sparse matrix accumulate block: it drives
// load, accumulate, read and clear items and checks each result against a
// shadow copy of the matrix. Depends on smacc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
   import smacc_pkg::*;

   // Result status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   // Request codes that the block does not implement.
   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   localparam int IDLE_PCT      = 23;
   localparam int RANDOM_ITEMS  = 480;
   localparam int MAX_SCAN      = 64;
   localparam int LONG_HOLD     = 400;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic                drain_first;
      logic [REQ_W-1:0]    kind;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [ADDR_W-1:0]   addr;
      logic [PTR_W-1:0]    load_data;
      logic [VALUE_W-1:0]  contribution;
   } request_type;

   typedef struct packed {
      logic                status;
      logic [POS_W-1:0]    position;
      logic [VALUE_W-1:0]  value;
   } result_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   sparse_matrix_accumulate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Items waiting to be offered, and results owed by the block in order.
   request_type request_q[$];
   result_type  due_results[$];
   request_type offered_req;

   int unsigned req_count = 0;
   int unsigned rsp_count = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   bit          long_hold_done = 1'b0;
   bit          drain_next = 1'b0;
   logic        no_gaps;

   // Both sides run without gaps over one window of items.
   assign no_gaps = (req_count >= 300 && req_count < 420);

   // Shadow matrix used to work out each result.
   bit [PTR_W-1:0]   shadow_ptr   [CS_DEPTH];
   bit [ROW_W-1:0]   shadow_row   [NUM_NONZERO];
   bit [VALUE_W-1:0] shadow_value [NUM_NONZERO];

   // Structure as the stimulus plans it, so that accumulates only scan
   // entries that were loaded.
   int               plan_ptr     [CS_DEPTH];
   bit               plan_ptr_set [CS_DEPTH];
   logic [ROW_W-1:0] plan_row     [NUM_NONZERO];
   bit               plan_row_set [NUM_NONZERO];

   // Apply one item to the shadow matrix and return the result it causes.
   task automatic predict_result(input request_type r, output result_type res);
      int k, stop, c;
      bit hit;
      logic [VALUE_W:0] wide_sum;
      res.status = STATUS_OK;
      res.position = r.addr;
      res.value = '0;
      // A 12-bit address is always below NUM_NONZERO, so entry items never miss.
      case (r.kind)
         REQ_LOAD_PTR: begin
            if (r.addr > NUM_DOF) res.status = STATUS_MISS;
            else shadow_ptr[r.addr] = r.load_data;
         end
         REQ_LOAD_ROW: shadow_row[r.addr] = r.load_data[ROW_W-1:0];
         REQ_ACCUM: begin
            c = r.col;
            k = shadow_ptr[c];
            stop = shadow_ptr[c+1];
            hit = 1'b0;
            res.position = '0;
            while (!hit && k < stop && k < NUM_NONZERO) begin
               if (shadow_row[k] == r.row) hit = 1'b1;
               else k++;
            end
            if (hit) begin
               // Saturating add on a sign-extended sum.
               wide_sum = {shadow_value[k][VALUE_W-1], shadow_value[k]} +
                          {r.contribution[VALUE_W-1], r.contribution};
               if (wide_sum[VALUE_W] != wide_sum[VALUE_W-1])
                  shadow_value[k] = wide_sum[VALUE_W] ? VALUE_MIN : VALUE_MAX;
               else
                  shadow_value[k] = wide_sum[VALUE_W-1:0];
               res.position = POS_W'(k);
               res.value = shadow_value[k];
            end else begin
               res.status = STATUS_MISS;
            end
         end
         REQ_READ: res.value = shadow_value[r.addr];
         REQ_CLEAR: shadow_value[r.addr] = '0;
         default: begin
            res.status = STATUS_MISS;
            res.position = '0;
         end
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] random_contribution();
      int pick, small_term;
      pick = $urandom_range(0, 99);
      if (pick < 30) return VALUE_W'({$urandom(), $urandom()});
      if (pick < 40) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return VALUE_W'(1);
            default: return '1;
         endcase
      end
      small_term = int'($urandom_range(0, 2097152)) - 1048576;
      return VALUE_W'(small_term);
   endfunction

   // An item of the given kind with every field random; callers set the ones
   // that matter.
   function automatic request_type random_request(input logic [REQ_W-1:0] kind);
      request_type r;
      r.drain_first = 1'b0;
      r.kind = kind;
      r.row = ROW_W'($urandom());
      r.col = COL_W'($urandom());
      r.addr = ADDR_W'($urandom());
      r.load_data = PTR_W'($urandom_range(0, NUM_NONZERO));
      r.contribution = random_contribution();
      return r;
   endfunction

   task automatic add_request(input request_type r);
      r.drain_first = drain_next;
      drain_next = 1'b0;
      if (r.kind == REQ_LOAD_PTR && r.addr <= NUM_DOF) begin
         plan_ptr[r.addr] = r.load_data;
         plan_ptr_set[r.addr] = 1'b1;
      end
      if (r.kind == REQ_LOAD_ROW) begin
         plan_row[r.addr] = r.load_data[ROW_W-1:0];
         plan_row_set[r.addr] = 1'b1;
      end
      request_q = {request_q, r};
   endtask

   task automatic load_pointer(input int slot, input int value);
      request_type r;
      r = random_request(REQ_LOAD_PTR);
      r.addr = ADDR_W'(slot);
      r.load_data = PTR_W'(value);
      add_request(r);
   endtask

   task automatic load_row(input int pos, input int value);
      request_type r;
      r = random_request(REQ_LOAD_ROW);
      r.addr = ADDR_W'(pos);
      r.load_data = PTR_W'(value);
      add_request(r);
   endtask

   task automatic accumulate(input int c, input int row, input logic [VALUE_W-1:0] term);
      request_type r;
      r = random_request(REQ_ACCUM);
      r.col = COL_W'(c);
      r.row = ROW_W'(row);
      r.contribution = term;
      add_request(r);
   endtask

   task automatic access_value(input logic [REQ_W-1:0] kind, input int pos);
      request_type r;
      r = random_request(kind);
      r.addr = ADDR_W'(pos);
      add_request(r);
   endtask

   // Row indices for a run of entries; some repeat the previous row so that
   // the first of two matches is the one updated. Bits above the row index
   // carry junk that the block must drop.
   task automatic fill_rows(input int start, input int count);
      int row;
      for (int k = 0; k < count; k++) begin
         if (k > 0 && $urandom_range(0, 3) == 0) row = plan_row[start+k-1];
         else row = $urandom_range(0, 255);
         load_row(start + k, row | ($urandom_range(0, 15) << ROW_W));
      end
   endtask

   // A column may be accumulated when its scan touches only loaded entries
   // and stays short.
   function automatic bit column_usable(input int c);
      int s, e;
      if (!plan_ptr_set[c] || !plan_ptr_set[c+1]) return 1'b0;
      s = plan_ptr[c];
      e = plan_ptr[c+1];
      if (e > NUM_NONZERO) e = NUM_NONZERO;
      if (e <= s) return 1'b1;
      if (e - s > MAX_SCAN) return 1'b0;
      for (int k = s; k < e; k++)
         if (!plan_row_set[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int usable_column();
      int c;
      repeat (40) begin
         c = $urandom_range(0, NUM_DOF - 1);
         if (column_usable(c)) return c;
      end
      return -1;
   endfunction

   // Half the time a position inside a stored column, otherwise anywhere.
   function automatic int stored_position();
      int c, lo, hi;
      c = usable_column();
      if (c >= 0 && $urandom_range(0, 1) == 1) begin
         lo = plan_ptr[c];
         hi = plan_ptr[c+1];
         if (hi > NUM_NONZERO) hi = NUM_NONZERO;
         if (hi > lo) return $urandom_range(lo, hi - 1);
      end
      return $urandom_range(0, NUM_NONZERO - 1);
   endfunction

   // Sender: offers the head of the item queue, holds it until taken, and
   // predicts the result of every item accepted.
   always @(posedge clock) begin : request_driver
      result_type res;
      logic       accepted;
      logic       show;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         accepted = req_tvalid && req_tready;
         if (accepted) begin
            predict_result(offered_req, res);
            due_results = {due_results, res};
            req_count <= req_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            show = 1'b0;
            if (request_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
               // A marked item waits until every owed result has come.
               if (!request_q[0].drain_first || rsp_count == req_count + accepted) begin
                  offered_req = request_q.pop_front();
                  show = 1'b1;
               end
            end
            req_tvalid <= show;
            if (show) begin
               // tdata: row, col, addr, load_data, contribution from bit 0 up.
               req_tdata <= REQ_DATA_W'({offered_req.contribution, offered_req.load_data,
                                         offered_req.addr, offered_req.col, offered_req.row});
               req_tuser <= offered_req.kind;
            end
         end
      end
   end

   // Receiver: checks each result against the oldest owed one and stalls at
   // random, once for a long stretch.
   always @(posedge clock) begin : result_monitor
      result_type want;
      logic       ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_count >= req_count) begin
               $display("%0t: result %h arrived with none outstanding", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[0] !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[POS_W:1] !== want.position) begin
                  $display("%0t: position expected %0d got %0d", $time, want.position,
                           rsp_tdata[POS_W:1]);
                  fail_count++;
               end
               if (rsp_tdata[POS_W+VALUE_W:POS_W+1] !== want.value) begin
                  $display("%0t: value expected %h got %h", $time, want.value,
                           rsp_tdata[POS_W+VALUE_W:POS_W+1]);
                  fail_count++;
               end
            end
            rsp_count <= rsp_count + 1;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!long_hold_done && rsp_count >= 200) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = no_gaps || $urandom_range(0, 99) >= IDLE_PCT;
         end
         rsp_tready <= ready_next;
      end
   end

   // Ends the run when neither side has moved an item for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int c, s, e, len, pick, row, random_items, total;
      request_type r;

      // Directed structure: column 0 holds rows 5, 0, 5, 255; column 1 is
      // empty; column 2 has a reversed range; column 255 ends at the top of
      // the entry store.
      load_pointer(0, 0);
      load_pointer(1, 4);
      load_pointer(2, 4);
      load_pointer(3, 2);
      load_pointer(NUM_DOF - 1, NUM_NONZERO - 2);
      load_pointer(NUM_DOF, NUM_NONZERO);
      load_pointer(NUM_DOF + 1, 17);
      load_pointer(NUM_NONZERO - 1, 3);
      load_row(0, 5);
      load_row(1, NUM_NONZERO);
      load_row(2, 5);
      load_row(3, 255);
      load_row(NUM_NONZERO - 2, 7);
      load_row(NUM_NONZERO - 1, 200);

      // Saturation both ways, first of two matches, and every kind of miss.
      accumulate(0, 5, VALUE_MAX);
      accumulate(0, 5, VALUE_W'(1));
      accumulate(0, 0, VALUE_MIN);
      accumulate(0, 0, '1);
      accumulate(0, 255, random_contribution());
      accumulate(0, 77, random_contribution());
      accumulate(1, 5, random_contribution());
      accumulate(2, 5, random_contribution());
      accumulate(NUM_DOF - 1, 200, VALUE_MIN);
      accumulate(NUM_DOF - 1, 9, random_contribution());
      access_value(REQ_READ, 0);
      access_value(REQ_CLEAR, 0);
      access_value(REQ_READ, 0);
      add_request(random_request(REQ_UNUSED_LO));
      add_request(random_request(REQ_UNUSED_HI));

      // A contiguous run of columns to start the random part from.
      drain_next = 1'b1;
      s = 100;
      for (c = 8; c < 24; c++) begin
         load_pointer(c, s);
         len = $urandom_range(0, 10);
         fill_rows(s, len);
         s += len;
      end
      load_pointer(24, s);

      // Random part: mostly accumulates into loaded columns, with column
      // rebuilds, reads, clears, row rewrites and some noise.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= 350 && random_items < 360) drain_next = 1'b1;
         pick = $urandom_range(0, 99);
         c = usable_column();
         if (pick < 8 || (pick < 55 && c < 0)) begin
            c = $urandom_range(0, NUM_DOF - 1);
            len = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) s = NUM_NONZERO - len;
            else s = $urandom_range(0, NUM_NONZERO - 16);
            load_pointer(c, s);
            load_pointer(c + 1, s + len);
            fill_rows(s, len);
            random_items += len + 2;
         end else if (pick < 55) begin
            s = plan_ptr[c];
            e = plan_ptr[c+1];
            if (e > NUM_NONZERO) e = NUM_NONZERO;
            if (e > s && $urandom_range(0, 9) < 8) row = plan_row[$urandom_range(s, e - 1)];
            else row = $urandom_range(0, 255);
            accumulate(c, row, random_contribution());
            random_items++;
         end else if (pick < 70) begin
            access_value(REQ_READ, stored_position());
            random_items++;
         end else if (pick < 76) begin
            access_value(REQ_CLEAR, stored_position());
            random_items++;
         end else if (pick < 88) begin
            load_row(stored_position(), $urandom_range(0, NUM_NONZERO));
            random_items++;
         end else if (pick < 92) begin
            load_pointer($urandom_range(0, NUM_DOF), $urandom_range(0, NUM_NONZERO));
            random_items++;
         end else if (pick < 96) begin
            load_pointer($urandom_range(NUM_DOF + 1, NUM_NONZERO - 1),
                         $urandom_range(0, NUM_NONZERO));
            random_items++;
         end else begin
            r = random_request(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)));
            add_request(r);
            random_items++;
         end
      end
      total = request_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (req_count == total && rsp_count == total);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/smacc_pkg.sv
hdl/smacc_ram.sv
hdl/smacc_alu.sv
hdl/sparse_matrix_accumulate.sv
verif/tb.sv
